FILE: hw/rtl/sobel_edge_threshold_core_defines.svh
// ---------------------------------------------------------------------------
// Sobel edge threshold core - assertion macros
// Shared property forms for the core's checks; clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_THRESHOLD_CORE_DEFINES_SVH
`define SOBEL_EDGE_THRESHOLD_CORE_DEFINES_SVH

// same-cycle implication
`define SOBEL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SOBEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sobel_pkg.sv
// ---------------------------------------------------------------------------
// Sobel package
// Shared constants, configuration indexes and request/result types.
// ---------------------------------------------------------------------------
package sobel_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int WIDTH_HI     = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
    localparam int HEIGHT_HI    = 2048;
    localparam int SIZE_MIN     = 3;
    localparam int LS_DEPTH     = WIDTH_HI;
    localparam int LS_ADDR_W    = $clog2(LS_DEPTH);

    localparam int PIX_W        = 8;
    localparam int COORD_W      = 11;
    localparam int SIZE_W       = 12;
    localparam int THR_W        = 11;
    localparam int GRAD_W       = 11;
    localparam int MAG_W        = 10;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int THR2_W       = 2 * THR_W;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int THR_RESET    = 128;
    localparam int THR2_RESET   = THR_RESET * THR_RESET;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_COUNT_W    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] gray_pixel;
        logic             frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               is_edge;
        logic               frame_last;
    } result_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [COORD_W-1:0]       center_x;
        logic [COORD_W-1:0]       center_y;
        logic                     frame_last;
    } grad_item_t;

endpackage

FILE: hw/rtl/sobel_front.sv
// ---------------------------------------------------------------------------
// Sobel front end
// Accepts pixels, tracks position, keeps the line stores and the 3x3 window,
// and forms the two gradient sums for every interior centre.
// ---------------------------------------------------------------------------
module sobel_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  sobel_pkg::pixel_in_t                pixel,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [sobel_pkg::Q_COUNT_W-1:0]     q_count,
    output logic                                q_push,
    output sobel_pkg::grad_item_t               q_item,
    output logic [sobel_pkg::THR2_W-1:0]        thr2
);
    import sobel_pkg::*;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] hi
    );
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(SIZE_MIN))
            r = SIZE_W'(SIZE_MIN);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] col_sum(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c
    );
        return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    logic [SIZE_W-1:0]      width_reg;
    logic [SIZE_W-1:0]      height_reg;
    logic [THR2_W-1:0]      thr2_reg;

    logic                   clr_active_reg;
    logic [LS_ADDR_W-1:0]   clr_addr_reg;

    logic [COORD_W-1:0]     col_reg, col_next;
    logic [COORD_W-1:0]     line_reg, line_next;

    logic                   accept;
    logic [SIZE_W-1:0]      c0, l0, c1, l1, y12, xn, yn;
    logic [COORD_W-1:0]     x, y;
    logic                   emit, last, fwd;

    logic [2*PIX_W-1:0]     ls_mem [LS_DEPTH];
    logic [2*PIX_W-1:0]     ls_rdata_reg;
    logic                   ls_we;
    logic [LS_ADDR_W-1:0]   ls_waddr;
    logic [2*PIX_W-1:0]     ls_wdata;
    logic [2*PIX_W-1:0]     ls_word;

    logic                   s1_valid_reg;
    logic [COORD_W-1:0]     s1_x_reg;
    logic [PIX_W-1:0]       s1_pix_reg;
    logic                   s1_fwd_reg;
    logic [2*PIX_W-1:0]     s1_fwd_data_reg;
    logic                   s1_emit_reg;
    logic [COORD_W-1:0]     s1_cx_reg;
    logic [COORD_W-1:0]     s1_cy_reg;
    logic                   s1_last_reg;

    logic [PIX_W-1:0]       win_reg [6];
    logic [PIX_W-1:0]       rt, rm, rb;
    logic [MAG_W-1:0]       sum_r, sum_l, sum_b, sum_t;

    // configuration
    assign cfg_ready = 1'b1;
    assign thr2      = thr2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(WIDTH_RESET);
            height_reg <= SIZE_W'(HEIGHT_RESET);
            thr2_reg   <= THR2_W'(THR2_RESET);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_IMAGE_WIDTH)
                width_reg <= clamp_size(cfg_data, SIZE_W'(WIDTH_HI));
            else if (cfg_index == CFG_IMAGE_HEIGHT)
                height_reg <= clamp_size(cfg_data, SIZE_W'(HEIGHT_HI));
            else if (cfg_index == CFG_EDGE_THRESHOLD)
                thr2_reg <= THR2_W'(cfg_data[THR_W-1:0]) * THR2_W'(cfg_data[THR_W-1:0]);
        end
    end

    // clear the line stores after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LS_ADDR_W'(LS_DEPTH - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // accept when not clearing and the queue has room for every request in flight
    assign full   = clr_active_reg ||
                    (({1'b0, q_count} + (Q_COUNT_W+1)'(s1_valid_reg))
                        >= (Q_COUNT_W+1)'(Q_DEPTH));
    assign accept = push && !full;

    // position of the incoming pixel
    always_comb
    begin
        c0 = pixel.frame_start ? '0 : {1'b0, col_reg};
        l0 = pixel.frame_start ? '0 : {1'b0, line_reg};
        if (c0 >= width_reg)
        begin
            c1 = '0;
            l1 = l0 + 1'b1;
        end
        else
        begin
            c1 = c0;
            l1 = l0;
        end
        y12 = (l1 >= height_reg) ? '0 : l1;
        x   = c1[COORD_W-1:0];
        y   = y12[COORD_W-1:0];
        xn  = {1'b0, x} + 1'b1;
        yn  = {1'b0, y} + 1'b1;
        if (xn >= width_reg)
        begin
            col_next  = '0;
            line_next = (yn >= height_reg) ? '0 : yn[COORD_W-1:0];
        end
        else
        begin
            col_next  = xn[COORD_W-1:0];
            line_next = y;
        end
        emit = (x >= COORD_W'(2)) && (y >= COORD_W'(2));
        last = ({1'b0, x} == width_reg - 1'b1) && ({1'b0, y} == height_reg - 1'b1);
        fwd  = s1_valid_reg && (s1_x_reg == x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    // line stores: upper byte two lines back, lower byte one line back
    assign ls_we    = clr_active_reg || s1_valid_reg;
    assign ls_waddr = clr_active_reg ? clr_addr_reg : s1_x_reg[LS_ADDR_W-1:0];
    assign ls_wdata = clr_active_reg ? '0 : {rm, rb};

    always_ff @(posedge clk)
    begin
        if (ls_we)
            ls_mem[ls_waddr] <= ls_wdata;
        if (accept)
            ls_rdata_reg <= ls_mem[x[LS_ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg        <= x;
            s1_pix_reg      <= pixel.gray_pixel;
            s1_fwd_reg      <= fwd;
            s1_fwd_data_reg <= {rm, rb};
            s1_emit_reg     <= emit;
            s1_cx_reg       <= x - 1'b1;
            s1_cy_reg       <= y - 1'b1;
            s1_last_reg     <= last;
        end
    end

    // window column and gradients; take the word being written on a same-column hit
    assign ls_word = s1_fwd_reg ? s1_fwd_data_reg : ls_rdata_reg;
    assign rt      = ls_word[2*PIX_W-1:PIX_W];
    assign rm      = ls_word[PIX_W-1:0];
    assign rb      = s1_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= rt;
            win_reg[4] <= rm;
            win_reg[5] <= rb;
        end
    end

    assign sum_r = col_sum(rt, rm, rb);
    assign sum_l = col_sum(win_reg[0], win_reg[1], win_reg[2]);
    assign sum_b = col_sum(win_reg[2], win_reg[5], rb);
    assign sum_t = col_sum(win_reg[0], win_reg[3], rt);

    assign q_push            = s1_valid_reg && s1_emit_reg;
    assign q_item.gx         = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    assign q_item.gy         = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    assign q_item.center_x   = s1_cx_reg;
    assign q_item.center_y   = s1_cy_reg;
    assign q_item.frame_last = s1_last_reg;

endmodule

FILE: hw/rtl/sobel_queue.sv
// ---------------------------------------------------------------------------
// Sobel gradient queue
// Short first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
module sobel_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  sobel_pkg::grad_item_t            push_item,
    input  logic                             pop,
    output logic                             empty,
    output sobel_pkg::grad_item_t            pop_item,
    output logic [sobel_pkg::Q_COUNT_W-1:0]  count
);
    import sobel_pkg::*;

    grad_item_t           entries_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_COUNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign pop_item = entries_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: hw/rtl/sobel_back.sv
// ---------------------------------------------------------------------------
// Sobel back end
// Squares the gradients, compares against the squared threshold and holds
// the result for the output side.
// ---------------------------------------------------------------------------
module sobel_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  sobel_pkg::grad_item_t         q_item,
    output logic                          q_pop,
    input  logic [sobel_pkg::THR2_W-1:0]  thr2,
    output logic                          empty,
    input  logic                          pop,
    output sobel_pkg::result_t            result
);
    import sobel_pkg::*;

    logic               s2_valid_reg;
    logic [SQ_W-1:0]    s2_sqx_reg;
    logic [SQ_W-1:0]    s2_sqy_reg;
    logic [COORD_W-1:0] s2_cx_reg;
    logic [COORD_W-1:0] s2_cy_reg;
    logic               s2_last_reg;

    logic               out_valid_reg;
    result_t            out_reg;

    logic               out_ready, s2_ready;
    logic [MAG_W-1:0]   ax, ay;
    logic [THR2_W-1:0]  mag2;
    logic               hit;

    assign out_ready = !out_valid_reg || pop;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign q_pop     = !q_empty && s2_ready;

    assign ax   = q_item.gx[GRAD_W-1] ? MAG_W'(-q_item.gx) : MAG_W'(q_item.gx);
    assign ay   = q_item.gy[GRAD_W-1] ? MAG_W'(-q_item.gy) : MAG_W'(q_item.gy);
    assign mag2 = THR2_W'(s2_sqx_reg) + THR2_W'(s2_sqy_reg);
    assign hit  = mag2 > thr2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                s2_valid_reg <= !q_empty;
            if (out_ready)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s2_sqx_reg  <= SQ_W'(ax) * SQ_W'(ax);
            s2_sqy_reg  <= SQ_W'(ay) * SQ_W'(ay);
            s2_cx_reg   <= q_item.center_x;
            s2_cy_reg   <= q_item.center_y;
            s2_last_reg <= q_item.frame_last;
        end
        if (out_ready && s2_valid_reg)
        begin
            out_reg.center_x   <= s2_cx_reg;
            out_reg.center_y   <= s2_cy_reg;
            out_reg.is_edge    <= hit;
            out_reg.frame_last <= s2_last_reg;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

FILE: hw/rtl/sobel_edge_threshold_core.sv
// ---------------------------------------------------------------------------
// Sobel edge threshold core
// Streaming 3x3 Sobel edge detector with squared-magnitude threshold.
// ---------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  pixel     push / full            gray_pixel, frame_start
//  result    pop / empty            center_x, center_y, is_edge, frame_last
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One pixel request per clock while full is low; the line store does one
//  read and one write per cycle, which sets that rate.
//  A result passes the stage-one, queue, squaring and output registers.
//  After reset, full stays high while the line store clears; configuration
//  writes are taken throughout.
//  A stalled result side backs up through a four-entry queue into full.
// ---------------------------------------------------------------------------
`include "sobel_edge_threshold_core_defines.svh"

module sobel_edge_threshold_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  sobel_pkg::pixel_in_t              pixel,
    output logic                              empty,
    input  logic                              pop,
    output sobel_pkg::result_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sobel_pkg::*;

    logic                 q_push;
    logic                 q_pop;
    logic                 q_empty;
    logic [Q_COUNT_W-1:0] q_count;
    grad_item_t           q_in_item;
    grad_item_t           q_out_item;
    logic [THR2_W-1:0]    thr2;

    sobel_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_item    (q_in_item),
        .thr2      (thr2)
    );

    sobel_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (q_out_item),
        .count     (q_count)
    );

    sobel_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (q_out_item),
        .q_pop   (q_pop),
        .thr2    (thr2),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    `SOBEL_ASSERT_NOW(a_queue_no_overflow, q_push, q_count != Q_COUNT_W'(Q_DEPTH), "queue push when full")
    `SOBEL_ASSERT_NOW(a_queue_pop_valid, q_pop, !q_empty, "back end popped an empty queue")
    `SOBEL_ASSERT_NEXT(a_queue_stays_empty, q_empty && !q_push, q_empty, "queue filled without a push")

endmodule
